// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, suspended while reset is asserted.
`define CCSP_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("ccsp assertion failed");

// Clocked property that also holds across reset.
`define CCSP_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("ccsp assertion failed");

`endif

// ===== design/ccsp_pkg.sv =====
`timescale 1ns / 1ps
package ccsp_pkg;

  localparam int AUTHOR_LIMIT = 255;
  localparam int MAGIC_LENGTH = 4;
  localparam int QDEPTH       = 4;
  localparam int QAW          = $clog2(QDEPTH);
  localparam int QCW          = $clog2(QDEPTH + 1);

  localparam logic [3:0] REC_HEADER     = 4'd0;
  localparam logic [3:0] REC_AUTHOR     = 4'd1;
  localparam logic [3:0] REC_LAYOUT     = 4'd2;
  localparam logic [3:0] REC_ELEMENT    = 4'd3;
  localparam logic [3:0] REC_EXTENSION  = 4'd4;
  localparam logic [3:0] REC_CONTAINER  = 4'd5;
  localparam logic [3:0] REC_MEMBER     = 4'd6;
  localparam logic [3:0] REC_GROUP_END  = 4'd7;
  localparam logic [3:0] REC_CONT_END   = 4'd8;
  localparam logic [3:0] REC_UNSUPPORT  = 4'd9;
  localparam logic [3:0] REC_STREAM_END = 4'd10;

  localparam logic [2:0] CHUNK_CONTAINER = 3'd1;
  localparam logic [2:0] CHUNK_LAYOUT    = 3'd3;

  typedef struct packed {
    logic        has_main;
    logic        has_end;
    logic        end_trunc;
    logic [3:0]  kind;
    logic [12:0] chunk;
    logic [15:0] fa;
    logic [15:0] fb;
    logic [15:0] fc;
    logic [15:0] fd;
    logic [15:0] fe;
    logic [7:0]  flag;
  } ccsp_entry_t;

endpackage

// ===== design/content_chunk_stream_parser.sv =====
`timescale 1ns / 1ps
// Path: each result goes from the parser through the queue into the output register.
// Throughput: one byte per cycle while the queue is not full; a final byte that also
//   closes a record yields two output records, absorbed by the four-entry queue.
// Reset: synchronous, active low; clears parse state, queue pointers and output valid.
//   No clearing pass: the block can take bytes as soon as reset is released.
module content_chunk_stream_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_record_kind,
  output logic [12:0] out_chunk_id,
  output logic [15:0] out_field_a,
  output logic [15:0] out_field_b,
  output logic [15:0] out_field_c,
  output logic [15:0] out_field_d,
  output logic [15:0] out_field_e,
  output logic [7:0]  out_flag_byte,
  output logic        out_last_of_run
);
  import ccsp_pkg::*;

  logic        accept;
  logic        push, pop, q_full, head_valid;
  ccsp_entry_t push_entry, head_entry;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  ccsp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .data_byte  (in_data_byte),
    .final_byte (in_final_byte),
    .push       (push),
    .entry      (push_entry)
  );

  ccsp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  ccsp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_entry      (head_entry),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_record_kind (out_record_kind),
    .out_chunk_id    (out_chunk_id),
    .out_field_a     (out_field_a),
    .out_field_b     (out_field_b),
    .out_field_c     (out_field_c),
    .out_field_d     (out_field_d),
    .out_field_e     (out_field_e),
    .out_flag_byte   (out_flag_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// ===== design/ccsp_front.sv =====
`timescale 1ns / 1ps
module ccsp_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [7:0]            data_byte,
  input  logic                  final_byte,
  output logic                  push,
  output ccsp_pkg::ccsp_entry_t entry
);
  import ccsp_pkg::*;

  localparam logic [3:0] PH_MAGIC   = 4'd0;
  localparam logic [3:0] PH_HDR     = 4'd1;
  localparam logic [3:0] PH_AUTHOR  = 4'd2;
  localparam logic [3:0] PH_CHI     = 4'd3;
  localparam logic [3:0] PH_CLO     = 4'd4;
  localparam logic [3:0] PH_LCOUNT  = 4'd5;
  localparam logic [3:0] PH_ELEM    = 4'd6;
  localparam logic [3:0] PH_EXT     = 4'd7;
  localparam logic [3:0] PH_CLAYOUT = 4'd8;
  localparam logic [3:0] PH_SLOT    = 4'd9;
  localparam logic [3:0] PH_MLO     = 4'd10;
  localparam logic [3:0] PH_STOP    = 4'd11;
  localparam logic [3:0] PH_RESET   = (MAGIC_LENGTH == 0) ? PH_HDR : PH_MAGIC;

  logic [3:0]  phase_r, phase_nxt;
  logic [3:0]  pos_r, pos_nxt, pos_inc;
  logic [12:0] chunk_r, chunk_nxt;
  logic [7:0]  elem_r, elem_nxt, elem_dec;
  logic [7:0]  auth_r, auth_nxt;
  logic [7:0]  gidx_r, gidx_nxt;
  logic [15:0] mcnt_r, mcnt_nxt;
  logic        gstart_r, gstart_nxt;
  logic [7:0]  asm_r [10];
  logic        asm_we;
  logic [3:0]  asm_idx;
  logic [2:0]  ctype;

  assign pos_inc  = pos_r + 4'd1;
  assign elem_dec = elem_r - 8'd1;
  assign ctype    = asm_r[0][7:5];

  always_comb begin
    phase_nxt      = phase_r;
    pos_nxt        = pos_r;
    chunk_nxt      = chunk_r;
    elem_nxt       = elem_r;
    auth_nxt       = auth_r;
    gidx_nxt       = gidx_r;
    mcnt_nxt       = mcnt_r;
    gstart_nxt     = gstart_r;
    asm_we         = 1'b0;
    asm_idx        = pos_r;
    entry          = '0;
    entry.kind     = REC_HEADER;
    case (phase_r)
      PH_MAGIC: begin
        if (pos_inc >= 4'(MAGIC_LENGTH)) begin
          pos_nxt   = '0;
          phase_nxt = PH_HDR;
        end else begin
          pos_nxt = pos_inc;
        end
      end
      PH_HDR: begin
        asm_we = 1'b1;
        if (pos_r == 4'd3) begin
          entry.has_main = 1'b1;
          entry.kind     = REC_HEADER;
          entry.fa       = {asm_r[0], asm_r[1]};
          entry.fb       = {asm_r[2], data_byte};
          pos_nxt        = '0;
          phase_nxt      = PH_AUTHOR;
        end else begin
          pos_nxt = pos_inc;
        end
      end
      PH_AUTHOR: begin
        if (data_byte == 8'd0 || auth_r >= 8'(AUTHOR_LIMIT)) begin
          phase_nxt = PH_CHI;
        end else begin
          entry.has_main = 1'b1;
          entry.kind     = REC_AUTHOR;
          entry.fa       = {8'd0, data_byte};
          auth_nxt       = auth_r + 8'd1;
        end
      end
      PH_CHI: begin
        asm_we    = 1'b1;
        asm_idx   = '0;
        phase_nxt = PH_CLO;
      end
      PH_CLO: begin
        chunk_nxt = {asm_r[0][4:0], data_byte};
        pos_nxt   = '0;
        if (ctype == CHUNK_CONTAINER) begin
          phase_nxt = PH_CLAYOUT;
        end else if (ctype == CHUNK_LAYOUT) begin
          phase_nxt = PH_LCOUNT;
        end else begin
          entry.has_main = 1'b1;
          entry.kind     = REC_UNSUPPORT;
          entry.fa       = {13'd0, ctype};
          phase_nxt      = PH_STOP;
        end
      end
      PH_LCOUNT: begin
        entry.has_main = 1'b1;
        entry.kind     = REC_LAYOUT;
        entry.fa       = {8'd0, data_byte};
        elem_nxt       = data_byte;
        pos_nxt        = '0;
        phase_nxt      = (data_byte == 8'd0) ? PH_CHI : PH_ELEM;
      end
      PH_ELEM: begin
        asm_we = 1'b1;
        if (pos_r == 4'd8) begin
          entry.has_main = 1'b1;
          entry.kind     = REC_ELEMENT;
          entry.fa       = {asm_r[0], asm_r[1]};
          entry.fb       = {asm_r[2], asm_r[3]};
          entry.fc       = {asm_r[4], asm_r[5]};
          entry.fd       = {asm_r[6], asm_r[7]};
          entry.flag     = data_byte;
          pos_nxt        = '0;
          if (data_byte[7]) begin
            phase_nxt = PH_EXT;
          end else begin
            elem_nxt  = elem_dec;
            phase_nxt = (elem_dec == 8'd0) ? PH_CHI : PH_ELEM;
          end
        end else begin
          pos_nxt = pos_inc;
        end
      end
      PH_EXT: begin
        asm_we = 1'b1;
        if (pos_r == 4'd9) begin
          entry.has_main = 1'b1;
          entry.kind     = REC_EXTENSION;
          entry.fa       = {asm_r[0], asm_r[1]};
          entry.fb       = {asm_r[2], asm_r[3]};
          entry.fc       = {asm_r[4], asm_r[5]};
          entry.fd       = {asm_r[6], asm_r[7]};
          entry.fe       = {asm_r[8], data_byte};
          pos_nxt        = '0;
          elem_nxt       = elem_dec;
          phase_nxt      = (elem_dec == 8'd0) ? PH_CHI : PH_ELEM;
        end else begin
          pos_nxt = pos_inc;
        end
      end
      PH_CLAYOUT: begin
        asm_we = 1'b1;
        if (pos_r == 4'd1) begin
          entry.has_main = 1'b1;
          entry.kind     = REC_CONTAINER;
          entry.fa       = {3'd0, asm_r[0][4:0], data_byte};
          gidx_nxt       = '0;
          mcnt_nxt       = '0;
          gstart_nxt     = 1'b0;
          pos_nxt        = '0;
          phase_nxt      = PH_SLOT;
        end else begin
          pos_nxt = pos_inc;
        end
      end
      PH_SLOT: begin
        if (data_byte == 8'hFF) begin
          entry.has_main = 1'b1;
          entry.kind     = REC_GROUP_END;
          entry.fa       = mcnt_r;
          entry.fb       = {8'd0, gidx_r};
          gidx_nxt       = gidx_r + 8'd1;
          mcnt_nxt       = '0;
          gstart_nxt     = 1'b0;
        end else if (data_byte == 8'd0 && !gstart_r) begin
          entry.has_main = 1'b1;
          entry.kind     = REC_CONT_END;
          entry.fb       = {8'd0, gidx_r};
          phase_nxt      = PH_CHI;
        end else begin
          asm_we     = 1'b1;
          asm_idx    = '0;
          gstart_nxt = 1'b1;
          phase_nxt  = PH_MLO;
        end
      end
      PH_MLO: begin
        entry.has_main = 1'b1;
        entry.kind     = REC_MEMBER;
        entry.fa       = {asm_r[0], data_byte};
        entry.fb       = {8'd0, gidx_r};
        mcnt_nxt       = mcnt_r + 16'd1;
        phase_nxt      = PH_SLOT;
      end
      default: begin
        phase_nxt = PH_STOP;
      end
    endcase
    entry.chunk = chunk_nxt;
    if (final_byte) begin
      entry.has_end   = 1'b1;
      entry.end_trunc = (phase_nxt != PH_CHI);
      phase_nxt       = PH_RESET;
      pos_nxt         = '0;
      chunk_nxt       = '0;
      elem_nxt        = '0;
      auth_nxt        = '0;
      gidx_nxt        = '0;
      mcnt_nxt        = '0;
      gstart_nxt      = 1'b0;
    end
  end

  assign push = accept && (entry.has_main || entry.has_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_RESET;
      pos_r    <= '0;
      chunk_r  <= '0;
      elem_r   <= '0;
      auth_r   <= '0;
      gidx_r   <= '0;
      mcnt_r   <= '0;
      gstart_r <= 1'b0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      chunk_r  <= chunk_nxt;
      elem_r   <= elem_nxt;
      auth_r   <= auth_nxt;
      gidx_r   <= gidx_nxt;
      mcnt_r   <= mcnt_nxt;
      gstart_r <= gstart_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && asm_we) begin
      asm_r[asm_idx] <= data_byte;
    end
  end

endmodule

// ===== design/ccsp_queue.sv =====
`timescale 1ns / 1ps
module ccsp_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  ccsp_pkg::ccsp_entry_t push_entry,
  input  logic                  pop,
  output logic                  full,
  output logic                  head_valid,
  output ccsp_pkg::ccsp_entry_t head_entry
);
  import ccsp_pkg::*;

  ccsp_entry_t        slot_r [QDEPTH];
  logic [QAW-1:0]     wr_r, wr_nxt;
  logic [QAW-1:0]     rd_r, rd_nxt;
  logic [QCW-1:0]     cnt_r, cnt_nxt;
  logic               do_pop;

  assign full       = (cnt_r == QCW'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_entry = slot_r[rd_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_nxt  = push ? wr_r + QAW'(1) : wr_r;
    rd_nxt  = do_pop ? rd_r + QAW'(1) : rd_r;
    cnt_nxt = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + QCW'(1);
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_entry;
    end
  end

endmodule

// ===== design/ccsp_back.sv =====
`timescale 1ns / 1ps
module ccsp_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_valid,
  input  ccsp_pkg::ccsp_entry_t head_entry,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [3:0]            out_record_kind,
  output logic [12:0]           out_chunk_id,
  output logic [15:0]           out_field_a,
  output logic [15:0]           out_field_b,
  output logic [15:0]           out_field_c,
  output logic [15:0]           out_field_d,
  output logic [15:0]           out_field_e,
  output logic [7:0]            out_flag_byte,
  output logic                  out_last_of_run
);
  import ccsp_pkg::*;

  logic        valid_r;
  logic        sub_r, sub_nxt;
  logic        advance, load;
  logic [3:0]  kind_nxt, kind_r;
  logic [15:0] fa_nxt, fb_nxt, fc_nxt, fd_nxt, fe_nxt;
  logic [15:0] fa_r, fb_r, fc_r, fd_r, fe_r;
  logic [7:0]  flag_nxt, flag_r;
  logic        last_nxt, last_r;
  logic [12:0] chunk_r;

  assign advance = !valid_r || !out_stall;

  always_comb begin
    load     = 1'b0;
    pop      = 1'b0;
    sub_nxt  = sub_r;
    kind_nxt = REC_STREAM_END;
    fa_nxt   = '0;
    fb_nxt   = '0;
    fc_nxt   = '0;
    fd_nxt   = '0;
    fe_nxt   = '0;
    flag_nxt = {7'd0, head_entry.end_trunc};
    last_nxt = 1'b1;
    if (advance && head_valid) begin
      load = 1'b1;
      if (!sub_r && head_entry.has_main) begin
        kind_nxt = head_entry.kind;
        fa_nxt   = head_entry.fa;
        fb_nxt   = head_entry.fb;
        fc_nxt   = head_entry.fc;
        fd_nxt   = head_entry.fd;
        fe_nxt   = head_entry.fe;
        flag_nxt = head_entry.flag;
        last_nxt = !head_entry.has_end;
        if (head_entry.has_end) begin
          sub_nxt = 1'b1;
        end else begin
          pop = 1'b1;
        end
      end else begin
        pop     = 1'b1;
        sub_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sub_r   <= 1'b0;
    end else begin
      sub_r <= sub_nxt;
      if (advance) begin
        valid_r <= load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= kind_nxt;
      chunk_r <= head_entry.chunk;
      fa_r    <= fa_nxt;
      fb_r    <= fb_nxt;
      fc_r    <= fc_nxt;
      fd_r    <= fd_nxt;
      fe_r    <= fe_nxt;
      flag_r  <= flag_nxt;
      last_r  <= last_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign out_record_kind = kind_r;
  assign out_chunk_id    = chunk_r;
  assign out_field_a     = fa_r;
  assign out_field_b     = fb_r;
  assign out_field_c     = fc_r;
  assign out_field_d     = fd_r;
  assign out_field_e     = fe_r;
  assign out_flag_byte   = flag_r;
  assign out_last_of_run = last_r;

endmodule

// ===== design/ccsp_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ccsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_record_kind,
  input logic [12:0] out_chunk_id,
  input logic [15:0] out_field_a,
  input logic [15:0] out_field_b,
  input logic [7:0]  out_flag_byte,
  input logic        out_last_of_run
);
  import ccsp_pkg::*;

  `CCSP_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid)
  `CCSP_ASSERT(a_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable({out_record_kind, out_chunk_id, out_field_a, out_field_b, out_flag_byte, out_last_of_run}))
  `CCSP_ASSERT(a_end_is_last, clk, rst_n, out_valid && out_record_kind == REC_STREAM_END |-> out_last_of_run)
  `CCSP_ASSERT(a_end_follows, clk, rst_n, out_valid && !out_stall && !out_last_of_run |=> out_valid && out_record_kind == REC_STREAM_END)

endmodule

bind content_chunk_stream_parser ccsp_checker u_ccsp_checker (.*);
